// ----- rtl/core/fjop_pkg.sv -----
package fjop_pkg;

    typedef enum logic [3:0] {
        P_OPEN   = 4'd0,
        P_FIRST  = 4'd1,
        P_KEY    = 4'd2,
        P_COLON  = 4'd3,
        P_VALUE  = 4'd4,
        P_STR    = 4'd5,
        P_ESC    = 4'd6,
        P_HEX1   = 4'd7,
        P_BSL2   = 4'd8,
        P_U2     = 4'd9,
        P_HEX2   = 4'd10,
        P_INT    = 4'd11,
        P_LIT    = 4'd12,
        P_AFTER  = 4'd13,
        P_DONE   = 4'd14,
        P_FAILED = 4'd15
    } t_phase;

    typedef enum logic [3:0] {
        EV_KEY_BYTE = 4'd0,
        EV_KEY_END  = 4'd1,
        EV_STR_BYTE = 4'd2,
        EV_STR_END  = 4'd3,
        EV_INT      = 4'd4,
        EV_TRUE     = 4'd5,
        EV_FALSE    = 4'd6,
        EV_NULL     = 4'd7,
        EV_CLOSED   = 4'd8,
        EV_ACCEPT   = 4'd9,
        EV_ERROR    = 4'd10
    } t_event;

    typedef enum logic [3:0] {
        ERR_OPEN    = 4'd0,
        ERR_KEY     = 4'd1,
        ERR_COLON   = 4'd2,
        ERR_SEP     = 4'd3,
        ERR_VALUE   = 4'd4,
        ERR_INT     = 4'd5,
        ERR_RANGE   = 4'd6,
        ERR_CTRL    = 4'd7,
        ERR_ESC     = 4'd8,
        ERR_HEX     = 4'd9,
        ERR_LOW     = 4'd10,
        ERR_NOU     = 4'd11,
        ERR_BADLOW  = 4'd12,
        ERR_EOD     = 4'd13,
        ERR_TRAIL   = 4'd14
    } t_err;

    // classified request from the front part; the back part expands it
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_EV    = 3'd1,
        OP_CP    = 3'd2,
        OP_INTEV = 3'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        is_key;
        t_event      ev;
        logic [7:0]  data;
        logic [20:0] cp;
        logic [63:0] ival;
        logic        tail_ev;
        t_event      ev2;
        t_err        err2;
        t_err        err;
    } t_cmd;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [63:0] ival;
        t_err        err;
        logic        last;
    } t_res;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam logic [63:0] LIM_POS_DIV = 64'd922337203685477580;

    function automatic logic is_ws(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b0, c[3:0] + 4'd9};
        return r;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        unique case (k)
            2'd0: unique case (i)
                3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e"; default: r = 8'h00;
            endcase
            2'd1: unique case (i)
                3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
                default: r = 8'h00;
            endcase
            2'd2: unique case (i)
                3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l"; default: r = 8'h00;
            endcase
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/fjop_front.sv -----
module fjop_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_kind,
    input  logic [7:0]    i_in_byte,
    output logic          o_full,
    output fjop_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_full
);
    import fjop_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_key, n_key;
    logic [15:0] r_hex, n_hex;
    logic [2:0]  r_hcnt, n_hcnt;
    logic [9:0]  r_hs, n_hs;
    logic [63:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic        r_hasd, n_hasd;
    logic [1:0]  r_lk, n_lk;
    logic [2:0]  r_li, n_li;
    t_cmd        c;
    logic        fire;
    logic [4:0]  h;
    logic [15:0] acc;
    logic [3:0]  d;
    logic [63:0] lim_div;
    logic [3:0]  lim_mod;
    logic [63:0] mag10;
    logic [63:0] sval;
    logic [7:0]  ch;
    logic [2:0]  llen;
    t_phase      pa;

    assign o_full      = i_cmd_full;
    assign fire        = i_push && !i_cmd_full;
    assign o_cmd       = c;
    assign o_cmd_valid = fire && c.op != OP_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_OPEN;
            r_key   <= 1'b0;
            r_hex   <= '0;
            r_hcnt  <= '0;
            r_hs    <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_hasd  <= 1'b0;
            r_lk    <= '0;
            r_li    <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_key   <= n_key;
            r_hex   <= n_hex;
            r_hcnt  <= n_hcnt;
            r_hs    <= n_hs;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_hasd  <= n_hasd;
            r_lk    <= n_lk;
            r_li    <= n_li;
        end
    end

    always_comb begin
        ch      = i_in_byte;
        n_phase = r_phase;
        n_key   = r_key;
        n_hex   = r_hex;
        n_hcnt  = r_hcnt;
        n_hs    = r_hs;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_hasd  = r_hasd;
        n_lk    = r_lk;
        n_li    = r_li;
        c         = '0;
        c.op      = OP_NONE;
        c.is_key  = r_key;
        c.ev      = EV_KEY_BYTE;
        c.ev2     = EV_ERROR;
        c.err     = ERR_OPEN;
        c.err2    = ERR_OPEN;
        h         = hex_val(ch);
        acc       = {r_hex[11:0], h[3:0]};
        d         = ch[3:0];
        lim_div   = LIM_POS_DIV;
        lim_mod   = r_neg ? 4'd8 : 4'd7;
        mag10     = (r_mag << 3) + (r_mag << 1);
        sval      = r_neg ? (64'd0 - r_mag) : r_mag;
        llen      = (r_lk == 2'd1) ? 3'd5 : 3'd4;
        pa        = P_AFTER;
        if (i_kind) begin
            c.op = OP_EV;
            c.ev = EV_ERROR;
            unique case (r_phase)
                P_OPEN:                          c.err = ERR_OPEN;
                P_FIRST, P_KEY:                  c.err = ERR_KEY;
                P_COLON:                         c.err = ERR_COLON;
                P_VALUE, P_LIT:                  c.err = ERR_VALUE;
                P_STR, P_ESC, P_HEX1, P_HEX2:    c.err = ERR_EOD;
                P_BSL2, P_U2:                    c.err = ERR_NOU;
                P_AFTER:                         c.err = ERR_SEP;
                P_INT: begin
                    if (r_hasd) begin
                        c.op      = OP_INTEV;
                        c.ival    = sval;
                        c.tail_ev = 1'b1;
                        c.ev2     = EV_ERROR;
                        c.err2    = ERR_SEP;
                    end else begin
                        c.err = ERR_INT;
                    end
                end
                P_DONE:                          c.ev = EV_ACCEPT;
                P_FAILED:                        c.op = OP_NONE;
                default:                         c.op = OP_NONE;
            endcase
            n_phase = P_OPEN;
            n_key = 1'b0; n_hex = '0; n_hcnt = '0; n_hs = '0; n_mag = '0;
            n_neg = 1'b0; n_hasd = 1'b0; n_lk = '0; n_li = '0;
        end else begin
            unique case (r_phase)
                P_OPEN: begin
                    if (ch == "{") n_phase = P_FIRST;
                    else if (!is_ws(ch)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_OPEN; n_phase = P_FAILED;
                    end
                end
                P_FIRST, P_KEY: begin
                    if (ch == "}" && r_phase == P_FIRST) begin
                        c.op = OP_EV; c.ev = EV_CLOSED; n_phase = P_DONE;
                    end else if (ch == "\"") begin
                        n_key = 1'b1; n_phase = P_STR;
                    end else if (!is_ws(ch)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_KEY; n_phase = P_FAILED;
                    end
                end
                P_COLON: begin
                    if (ch == ":") n_phase = P_VALUE;
                    else if (!is_ws(ch)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_COLON; n_phase = P_FAILED;
                    end
                end
                P_VALUE: begin
                    if (is_ws(ch)) begin
                        n_phase = P_VALUE;
                    end else if (ch == "\"") begin
                        n_key = 1'b0; n_phase = P_STR;
                    end else if (ch == "-" || (ch >= "0" && ch <= "9")) begin
                        n_neg   = (ch == "-");
                        n_hasd  = (ch != "-");
                        n_mag   = (ch == "-") ? 64'd0 : {60'd0, d};
                        n_phase = P_INT;
                    end else if (ch == "t" || ch == "f" || ch == "n") begin
                        n_lk    = (ch == "t") ? 2'd0 : (ch == "f") ? 2'd1 : 2'd2;
                        n_li    = 3'd1;
                        n_phase = P_LIT;
                    end else begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_VALUE; n_phase = P_FAILED;
                    end
                end
                P_STR: begin
                    if (ch == "\"") begin
                        c.op = OP_EV; c.ev = r_key ? EV_KEY_END : EV_STR_END;
                        n_phase = r_key ? P_COLON : P_AFTER;
                    end else if (ch < 8'h20) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_CTRL; n_phase = P_FAILED;
                    end else if (ch == "\\") begin
                        n_phase = P_ESC;
                    end else begin
                        // raw bytes pass through as they are, with no UTF-8 encoding
                        c.op = OP_EV; c.ev = r_key ? EV_KEY_BYTE : EV_STR_BYTE; c.data = ch;
                    end
                end
                P_ESC: begin
                    n_phase = P_STR;
                    c.op = OP_CP;
                    priority case (ch)
                        "\"", "\\", "/": c.cp = {13'd0, ch};
                        "b": c.cp = 21'h08;
                        "f": c.cp = 21'h0c;
                        "n": c.cp = 21'h0a;
                        "r": c.cp = 21'h0d;
                        "t": c.cp = 21'h09;
                        "u": begin
                            c.op = OP_NONE; n_hex = '0; n_hcnt = '0; n_phase = P_HEX1;
                        end
                        default: begin
                            c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_ESC;
                            n_phase = P_FAILED;
                        end
                    endcase
                end
                P_HEX1, P_HEX2: begin
                    if (h[4]) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_HEX; n_phase = P_FAILED;
                    end else begin
                        n_hex  = acc;
                        n_hcnt = r_hcnt + 3'd1;
                        if (r_hcnt == 3'd3) begin
                            n_hcnt = '0;
                            if (r_phase == P_HEX1) begin
                                if (acc >= 16'hd800 && acc <= 16'hdbff) begin
                                    n_hs = acc[9:0]; n_phase = P_BSL2;
                                end else if (acc >= 16'hdc00 && acc <= 16'hdfff) begin
                                    c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_LOW;
                                    n_phase = P_FAILED;
                                end else begin
                                    c.op = OP_CP; c.cp = {5'd0, acc}; n_phase = P_STR;
                                end
                            end else if (acc < 16'hdc00 || acc > 16'hdfff) begin
                                c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_BADLOW;
                                n_phase = P_FAILED;
                            end else begin
                                c.op = OP_CP;
                                c.cp = 21'h10000 + {1'b0, r_hs, acc[9:0]};
                                n_phase = P_STR;
                            end
                        end
                    end
                end
                P_BSL2: begin
                    if (ch == "\\") n_phase = P_U2;
                    else begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_NOU; n_phase = P_FAILED;
                    end
                end
                P_U2: begin
                    if (ch == "u") begin
                        n_hex = '0; n_hcnt = '0; n_phase = P_HEX2;
                    end else begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_NOU; n_phase = P_FAILED;
                    end
                end
                P_INT: begin
                    if (ch >= "0" && ch <= "9") begin
                        if (r_mag > lim_div || (r_mag == lim_div && d > lim_mod)) begin
                            c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_RANGE;
                            n_phase = P_FAILED;
                        end else begin
                            n_mag  = mag10 + {60'd0, d};
                            n_hasd = 1'b1;
                        end
                    end else if (!r_hasd) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_INT; n_phase = P_FAILED;
                    end else begin
                        // integer ends; the byte is then taken as a byte after a value
                        c.op   = OP_INTEV;
                        c.ival = sval;
                        if (ch == ",") pa = P_KEY;
                        else if (ch == "}") begin
                            c.tail_ev = 1'b1; c.ev2 = EV_CLOSED; pa = P_DONE;
                        end else if (!is_ws(ch)) begin
                            c.tail_ev = 1'b1; c.ev2 = EV_ERROR; c.err2 = ERR_SEP;
                            pa = P_FAILED;
                        end
                        n_phase = pa;
                    end
                end
                P_LIT: begin
                    if (r_li >= llen || ch != lit_char(r_lk, r_li)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_VALUE; n_phase = P_FAILED;
                    end else begin
                        n_li = r_li + 3'd1;
                        if (r_li + 3'd1 == llen) begin
                            c.op = OP_EV;
                            c.ev = t_event'(4'd5 + {2'd0, r_lk});
                            n_phase = P_AFTER;
                        end
                    end
                end
                P_AFTER: begin
                    if (ch == ",") n_phase = P_KEY;
                    else if (ch == "}") begin
                        c.op = OP_EV; c.ev = EV_CLOSED; n_phase = P_DONE;
                    end else if (!is_ws(ch)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_SEP; n_phase = P_FAILED;
                    end
                end
                P_DONE: begin
                    if (!is_ws(ch)) begin
                        c.op = OP_EV; c.ev = EV_ERROR; c.err = ERR_TRAIL; n_phase = P_FAILED;
                    end
                end
                P_FAILED: n_phase = P_FAILED;
                default:  n_phase = P_FAILED;
            endcase
        end
    end

endmodule

// ----- rtl/core/fjop_queue.sv -----
module fjop_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  fjop_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_empty,
    output fjop_pkg::t_cmd o_cmd,
    input  logic           i_rd
);
    import fjop_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = r_cnt == QAW'(0) + (QAW+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 1'b1;
            if (i_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(i_wr) - (QAW+1)'(i_rd);
        end
    end

endmodule

// ----- rtl/core/fjop_back.sv -----
module fjop_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fjop_pkg::t_cmd i_cmd,
    output logic           o_rd,
    output logic           o_empty,
    output fjop_pkg::t_res o_res,
    input  logic           i_pop
);
    import fjop_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic [1:0] cnt;
    t_res       cur;
    t_res       r_out;
    logic       r_ovld;
    logic       take;
    logic [20:0] cp;
    t_event     dev;

    always_comb begin
        cp  = i_cmd.cp;
        dev = i_cmd.is_key ? EV_KEY_BYTE : EV_STR_BYTE;
        cur      = '0;
        cur.ev   = i_cmd.ev;
        cur.err  = i_cmd.err;
        cnt      = 2'd0;
        unique case (i_cmd.op)
            OP_EV: begin
                cnt      = 2'd0;
                cur.data = i_cmd.data;
            end
            OP_INTEV: begin
                cnt = i_cmd.tail_ev ? 2'd1 : 2'd0;
                if (r_idx == 2'd0) begin
                    cur.ev = EV_INT; cur.ival = i_cmd.ival; cur.err = ERR_OPEN;
                end else begin
                    cur.ev = i_cmd.ev2; cur.err = i_cmd.err2;
                end
            end
            OP_CP: begin
                cur.ev = dev;
                cur.err = ERR_OPEN;
                if (cp <= 21'h7f) begin
                    cnt = 2'd0; cur.data = cp[7:0];
                end else if (cp <= 21'h7ff) begin
                    cnt = 2'd1;
                    cur.data = (r_idx == 2'd0) ? (8'hc0 | {2'd0, cp[11:6]})
                                               : (8'h80 | {2'd0, cp[5:0]});
                end else if (cp <= 21'hffff) begin
                    cnt = 2'd2;
                    unique case (r_idx)
                        2'd0:    cur.data = 8'he0 | {4'd0, cp[15:12]};
                        2'd1:    cur.data = 8'h80 | {2'd0, cp[11:6]};
                        default: cur.data = 8'h80 | {2'd0, cp[5:0]};
                    endcase
                end else begin
                    cnt = 2'd3;
                    unique case (r_idx)
                        2'd0:    cur.data = 8'hf0 | {5'd0, cp[20:18]};
                        2'd1:    cur.data = 8'h80 | {2'd0, cp[17:12]};
                        2'd2:    cur.data = 8'h80 | {2'd0, cp[11:6]};
                        default: cur.data = 8'h80 | {2'd0, cp[5:0]};
                    endcase
                end
            end
            default: cnt = 2'd0;
        endcase
        cur.last = r_idx == cnt;
    end

    assign take    = !i_empty && (!r_ovld || i_pop);
    assign o_rd    = take && cur.last;
    assign n_idx   = cur.last ? 2'd0 : r_idx + 2'd1;
    assign o_empty = !r_ovld;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (take) r_out <= cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (take) r_idx <= n_idx;
            if (take) r_ovld <= 1'b1;
            else if (i_pop) r_ovld <= 1'b0;
        end
    end

endmodule

// ----- rtl/core/flat_json_object_parser_core.sv -----
// Flat JSON object parser. Takes one document byte (or the end marker) per cycle
// on a push/full queue port and delivers decoded events on an empty/pop port.
// A front stage classifies each byte and queues a request; the back stage
// expands a request into its results, one per cycle while the receiver pops, so
// a \u escape yields up to four result bytes. Input is taken every cycle while
// the four-deep request queue has room.
module flat_json_object_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [7:0]  i_in_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_event_res,
    output logic [7:0]  o_data_byte,
    output logic signed [63:0] o_int_value,
    output logic [3:0]  o_error_code,
    output logic        o_last_of_run
);
    import fjop_pkg::*;

    t_cmd fcmd, qcmd;
    logic fvld, qfull, qempty, qrd;
    t_res res;

    fjop_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_kind, .i_in_byte,
        .o_full(full), .o_cmd(fcmd), .o_cmd_valid(fvld), .i_cmd_full(qfull)
    );

    fjop_queue u_queue (
        .i_clk, .i_rst_n, .i_wr(fvld), .i_cmd(fcmd), .o_full(qfull),
        .o_empty(qempty), .o_cmd(qcmd), .i_rd(qrd)
    );

    fjop_back u_back (
        .i_clk, .i_rst_n, .i_empty(qempty), .i_cmd(qcmd), .o_rd(qrd),
        .o_empty(empty), .o_res(res), .i_pop(pop)
    );

    assign o_event_res   = res.ev;
    assign o_data_byte   = res.data;
    assign o_int_value   = res.ival;
    assign o_error_code  = res.err;
    assign o_last_of_run = res.last;

endmodule

// ----- sim/fjop_checker.sv -----
module fjop_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  logic               full,
    input  logic               i_kind,
    input  logic [7:0]         i_in_byte,
    input  logic               empty,
    input  logic               pop,
    input  logic [3:0]         i_event_res,
    input  logic [7:0]         i_data_byte,
    input  logic signed [63:0] i_int_value,
    input  logic [3:0]         i_error_code,
    input  logic               i_last_of_run,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import fjop_pkg::*;

    t_phase      phase;
    logic        in_key;
    logic [15:0] hex_acc;
    logic [2:0]  hex_cnt;
    logic [9:0]  hi_sur;
    logic [63:0] magnitude;
    logic        negative;
    logic        seen_digit;
    logic [1:0]  lit_kind;
    logic [2:0]  lit_idx;

    t_res events_now[4];
    int   n_now;
    t_res expected_events[$];

    initial o_fail_count = 0;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic clear_state();
        phase      = P_OPEN;
        in_key     = 1'b0;
        hex_acc    = '0;
        hex_cnt    = '0;
        hi_sur     = '0;
        magnitude  = '0;
        negative   = 1'b0;
        seen_digit = 1'b0;
        lit_kind   = '0;
        lit_idx    = '0;
    endtask

    task automatic add_event(input t_event ev, input logic [7:0] b, input logic [63:0] iv,
                             input t_err e);
        if (n_now < 4) begin
            events_now[n_now] = '{ev: ev, data: b, ival: iv, err: e, last: 1'b0};
            n_now++;
        end
    endtask

    task automatic give_up(input t_err e);
        add_event(EV_ERROR, 8'h00, 64'd0, e);
        phase = P_FAILED;
    endtask

    task automatic add_text(input logic [7:0] b);
        add_event(in_key ? EV_KEY_BYTE : EV_STR_BYTE, b, 64'd0, ERR_OPEN);
    endtask

    task automatic add_utf8(input logic [20:0] cp);
        if (cp <= 21'h7f) begin
            add_text(cp[7:0]);
        end else if (cp <= 21'h7ff) begin
            add_text(8'hc0 | {3'd0, cp[10:6]});
            add_text(8'h80 | {2'd0, cp[5:0]});
        end else if (cp <= 21'hffff) begin
            add_text(8'he0 | {4'd0, cp[15:12]});
            add_text(8'h80 | {2'd0, cp[11:6]});
            add_text(8'h80 | {2'd0, cp[5:0]});
        end else begin
            add_text(8'hf0 | {5'd0, cp[20:18]});
            add_text(8'h80 | {2'd0, cp[17:12]});
            add_text(8'h80 | {2'd0, cp[11:6]});
            add_text(8'h80 | {2'd0, cp[5:0]});
        end
    endtask

    function automatic logic blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic string lit_word(input logic [1:0] k);
        return k == 2'd0 ? "true" : k == 2'd1 ? "false" : "null";
    endfunction

    task automatic add_int();
        add_event(EV_INT, 8'h00, negative ? -magnitude : magnitude, ERR_OPEN);
    endtask

    task automatic close_obj();
        add_event(EV_CLOSED, 8'h00, 64'd0, ERR_OPEN);
        phase = P_DONE;
    endtask

    task automatic after_value(input logic [7:0] c);
        if (c == ",") phase = P_KEY;
        else if (c == "}") close_obj();
        else if (!blank(c)) give_up(ERR_SEP);
    endtask

    task automatic take_byte(input logic [7:0] c);
        int h;
        logic [63:0] lim;
        logic [63:0] d;
        string w;
        case (phase)
            P_OPEN: begin
                if (c == "{") phase = P_FIRST;
                else if (!blank(c)) give_up(ERR_OPEN);
            end
            P_FIRST, P_KEY: begin
                if (c == "}" && phase == P_FIRST) close_obj();
                else if (c == "\"") begin in_key = 1'b1; phase = P_STR; end
                else if (!blank(c)) give_up(ERR_KEY);
            end
            P_COLON: begin
                if (c == ":") phase = P_VALUE;
                else if (!blank(c)) give_up(ERR_COLON);
            end
            P_VALUE: begin
                if (blank(c)) begin
                end else if (c == "\"") begin
                    in_key = 1'b0;
                    phase  = P_STR;
                end else if (c == "-" || (c >= "0" && c <= "9")) begin
                    negative   = (c == "-");
                    seen_digit = (c != "-");
                    magnitude  = (c == "-") ? 64'd0 : 64'(c - "0");
                    phase      = P_INT;
                end else if (c == "t" || c == "f" || c == "n") begin
                    lit_kind = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                    lit_idx  = 3'd1;
                    phase    = P_LIT;
                end else begin
                    give_up(ERR_VALUE);
                end
            end
            P_STR: begin
                if (c == "\"") begin
                    add_event(in_key ? EV_KEY_END : EV_STR_END, 8'h00, 64'd0, ERR_OPEN);
                    phase = in_key ? P_COLON : P_AFTER;
                end else if (c < 8'h20) give_up(ERR_CTRL);
                else if (c == 8'h5c) phase = P_ESC;
                else add_text(c);
            end
            P_ESC: begin
                phase = P_STR;
                case (c)
                    8'h22, 8'h5c, 8'h2f: add_text(c);
                    "b": add_text(8'h08);
                    "f": add_text(8'h0c);
                    "n": add_text(8'h0a);
                    "r": add_text(8'h0d);
                    "t": add_text(8'h09);
                    "u": begin hex_acc = '0; hex_cnt = '0; phase = P_HEX1; end
                    default: give_up(ERR_ESC);
                endcase
            end
            P_HEX1, P_HEX2: begin
                h = hex_digit(c);
                if (h < 0) begin
                    give_up(ERR_HEX);
                end else begin
                    hex_acc = {hex_acc[11:0], 4'(h)};
                    hex_cnt++;
                    if (hex_cnt == 3'd4) begin
                        hex_cnt = '0;
                        if (phase == P_HEX1) begin
                            if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                                hi_sur = 10'(hex_acc - 16'hd800);
                                phase  = P_BSL2;
                            end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                                give_up(ERR_LOW);
                            end else begin
                                add_utf8(21'(hex_acc));
                                phase = P_STR;
                            end
                        end else if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                            give_up(ERR_BADLOW);
                        end else begin
                            add_utf8(21'h10000 + (21'(hi_sur) << 10) + 21'(hex_acc - 16'hdc00));
                            phase = P_STR;
                        end
                    end
                end
            end
            P_BSL2: begin
                if (c == 8'h5c) phase = P_U2;
                else give_up(ERR_NOU);
            end
            P_U2: begin
                if (c == "u") begin hex_acc = '0; hex_cnt = '0; phase = P_HEX2; end
                else give_up(ERR_NOU);
            end
            P_INT: begin
                if (c >= "0" && c <= "9") begin
                    lim = negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
                    d   = 64'(c - "0");
                    if (magnitude > lim / 10 || (magnitude == lim / 10 && d > lim % 10)) begin
                        give_up(ERR_RANGE);
                    end else begin
                        magnitude  = magnitude * 10 + d;
                        seen_digit = 1'b1;
                    end
                end else if (!seen_digit) begin
                    give_up(ERR_INT);
                end else begin
                    add_int();
                    phase = P_AFTER;
                    after_value(c);
                end
            end
            P_LIT: begin
                w = lit_word(lit_kind);
                if (lit_idx >= w.len() || c != w[lit_idx]) begin
                    give_up(ERR_VALUE);
                end else begin
                    lit_idx++;
                    if (lit_idx == w.len()) begin
                        add_event(t_event'(EV_TRUE + lit_kind), 8'h00, 64'd0, ERR_OPEN);
                        phase = P_AFTER;
                    end
                end
            end
            P_AFTER: after_value(c);
            P_DONE: if (!blank(c)) give_up(ERR_TRAIL);
            default: ;
        endcase
    endtask

    task automatic take_end();
        case (phase)
            P_OPEN: give_up(ERR_OPEN);
            P_FIRST, P_KEY: give_up(ERR_KEY);
            P_COLON: give_up(ERR_COLON);
            P_VALUE, P_LIT: give_up(ERR_VALUE);
            P_STR, P_ESC, P_HEX1, P_HEX2: give_up(ERR_EOD);
            P_BSL2, P_U2: give_up(ERR_NOU);
            P_INT: begin
                if (seen_digit) begin add_int(); give_up(ERR_SEP); end
                else give_up(ERR_INT);
            end
            P_AFTER: give_up(ERR_SEP);
            P_DONE: add_event(EV_ACCEPT, 8'h00, 64'd0, ERR_OPEN);
            default: ;
        endcase
        clear_state();
    endtask

    always @(posedge i_clk) begin
        t_res w;
        if (!i_rst_n) begin
            clear_state();
            expected_events.delete();
        end else begin
            if (pop && !empty) begin
                if (expected_events.size() == 0) begin
                    report($sformatf("unexpected event %0d", i_event_res));
                end else begin
                    w = expected_events.pop_front();
                    if (i_event_res !== w.ev)
                        report($sformatf("event %0d, want %0d", i_event_res, w.ev));
                    if (i_data_byte !== w.data)
                        report($sformatf("data %h, want %h", i_data_byte, w.data));
                    if (i_int_value !== w.ival)
                        report($sformatf("int %0d, want %0d", i_int_value, $signed(w.ival)));
                    if (i_error_code !== w.err)
                        report($sformatf("code %0d, want %0d", i_error_code, w.err));
                    if (i_last_of_run !== w.last)
                        report($sformatf("last %b, want %b", i_last_of_run, w.last));
                end
            end
            if (push && !full) begin
                n_now = 0;
                if (i_kind) take_end();
                else take_byte(i_in_byte);
                if (n_now > 0) events_now[n_now - 1].last = 1'b1;
                for (int k = 0; k < n_now; k++)
                    expected_events.insert(expected_events.size(), events_now[k]);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// ----- sim/tb_flat_json_object_parser_core.sv -----
module tb_flat_json_object_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_kind = 1'b0;
    logic [7:0]         i_in_byte = 8'h00;
    logic               empty;
    logic               pop = 1'b0;
    logic [3:0]         o_event_res;
    logic [7:0]         o_data_byte;
    logic signed [63:0] o_int_value;
    logic [3:0]         o_error_code;
    logic               o_last_of_run;
    int                 fail_count;
    int                 pending;
    int                 hold_off = 0;
    int                 n_sent = 0;
    int                 cycles = 0;
    logic [7:0]         doc[$];

    always #5 i_clk = ~i_clk;

    flat_json_object_parser_core dut (
        .i_clk, .i_rst_n, .push, .full, .i_kind, .i_in_byte, .empty, .pop,
        .o_event_res, .o_data_byte, .o_int_value, .o_error_code, .o_last_of_run
    );

    fjop_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_kind, .i_in_byte, .empty, .pop,
        .i_event_res(o_event_res), .i_data_byte(o_data_byte), .i_int_value(o_int_value),
        .i_error_code(o_error_code), .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                pop <= 1'b0;
                hold_off--;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    pop <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                pop <= 1'b1;
            end
        end
    end

    task automatic send(input logic k, input logic [7:0] b, input bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push      <= 1'b1;
        i_kind    <= k;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic add_b(input logic [7:0] b);
        doc.insert(doc.size(), b);
    endtask

    task automatic add_s(input string s);
        for (int k = 0; k < s.len(); k++) add_b(s[k]);
    endtask

    task automatic add_ws();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: add_b(8'h20);
                1: add_b(8'h09);
                2: add_b(8'h0d);
                default: add_b(8'h0a);
            endcase
        end
    endtask

    task automatic add_hex4(input logic [15:0] v);
        add_s($urandom_range(0, 1) ? $sformatf("%04x", v) : $sformatf("%04X", v));
    endtask

    task automatic add_string();
        int n;
        logic [7:0] c;
        add_b(8'h22);
        n = $urandom_range(0, 3);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    c = 8'($urandom_range(8'h20, 8'h7e));
                    if (c == 8'h22 || c == 8'h5c) c = "a";
                    add_b(c);
                end
                2: add_b(8'($urandom_range(8'h80, 8'hff)));
                3: begin
                    add_b(8'h5c);
                    case ($urandom_range(0, 7))
                        0: add_b(8'h22);
                        1: add_b(8'h5c);
                        2: add_b("/");
                        3: add_b("b");
                        4: add_b("f");
                        5: add_b("n");
                        6: add_b("r");
                        default: add_b("t");
                    endcase
                end
                4: begin
                    add_s("\\u");
                    case ($urandom_range(0, 3))
                        0: add_hex4(16'($urandom_range(0, 16'h7f)));
                        1: add_hex4(16'($urandom_range(16'h80, 16'h7ff)));
                        2: add_hex4(16'($urandom_range(16'h800, 16'hd7ff)));
                        default: add_hex4(16'($urandom_range(16'he000, 16'hffff)));
                    endcase
                end
                default: begin
                    add_s("\\u");
                    add_hex4(16'($urandom_range(16'hd800, 16'hdbff)));
                    add_s("\\u");
                    add_hex4(16'($urandom_range(16'hdc00, 16'hdfff)));
                end
            endcase
        end
        add_b(8'h22);
    endtask

    task automatic add_value();
        longint v;
        case ($urandom_range(0, 5))
            0: add_string();
            1: begin
                case ($urandom_range(0, 5))
                    0: add_s("-9223372036854775808");
                    1: add_s("9223372036854775807");
                    2: add_s("9223372036854775808");
                    3: add_s("-9223372036854775809");
                    4: add_s("007");
                    default: begin
                        v = $urandom_range(0, 99999);
                        if ($urandom_range(0, 1)) v = -v;
                        add_s($sformatf("%0d", v));
                    end
                endcase
            end
            2: add_s("true");
            3: add_s("false");
            4: add_s("null");
            default: add_s($sformatf("%0d", $urandom_range(0, 9)));
        endcase
    endtask

    task automatic build_doc();
        int n;
        int r;
        doc.delete();
        r = $urandom_range(0, 9);
        if (r == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) add_b(8'($urandom_range(0, 255)));
            return;
        end
        add_ws();
        add_b("{");
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            if (k > 0) add_b(",");
            add_ws();
            add_string();
            add_ws();
            add_b(":");
            add_ws();
            add_value();
            add_ws();
        end
        add_b("}");
        add_ws();
        if (r <= 2) begin
            doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r == 3) begin
            n = $urandom_range(1, doc.size());
            while (doc.size() > n) void'(doc.pop_back());
        end
    endtask

    task automatic send_doc(input bit gaps);
        foreach (doc[k]) send(1'b0, doc[k], gaps);
        send(1'b1, 8'($urandom_range(0, 255)), gaps);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        doc.delete(); add_s("{}");                send_doc(1'b1);
        doc.delete(); add_s("x");                 send_doc(1'b1);
        doc.delete(); add_s("{\"k\":\"\\ud83d"); send_doc(1'b1);
        doc.delete(); add_s("{\"k\":tx}");        send_doc(1'b1);
        doc.delete(); add_s("{\"k\":-}");         send_doc(1'b1);

        // receiver stalls while requests keep coming, then drain fully
        doc.delete(); add_s("{\"abcdefghij\":\"klmnopqrstuv\",\"n\":12345}");
        hold_off = 300;
        send_doc(1'b0);
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        while (n_sent < 170) begin
            build_doc();
            send_doc(1'b1);
        end
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
